/* hw/rtl/decimal_up_down_counter_report_macros.svh */
// Assertion helpers for the counter RTL.
// Each expects signals named clk and arst_n in the module that uses it.
`ifndef DECIMAL_UP_DOWN_COUNTER_REPORT_MACROS_SVH
`define DECIMAL_UP_DOWN_COUNTER_REPORT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DUDC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dudc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DUDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dudc: next-cycle check failed");

`endif

/* hw/rtl/dudc_pkg.sv */
package dudc_pkg;

	localparam int COUNT_W = 14;
	localparam int SEG_W = 7;
	localparam int QUEUE_DEPTH = 2;

	// Input command codes
	localparam logic [1:0] CMD_INC = 2'd0;
	localparam logic [1:0] CMD_DEC = 2'd1;
	localparam logic [1:0] CMD_RX = 2'd2;
	localparam logic [1:0] CMD_REPORT = 2'd3;

	// Received characters that step the count
	localparam logic [7:0] CHAR_U_UPPER = 8'h55;
	localparam logic [7:0] CHAR_U_LOWER = 8'h75;
	localparam logic [7:0] CHAR_D_UPPER = 8'h44;
	localparam logic [7:0] CHAR_D_LOWER = 8'h64;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [1:0] {
		OP_UP = 2'd0,
		OP_DOWN = 2'd1,
		OP_REPORT = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic last_byte;
		logic [COUNT_W-1:0] count_value;
		logic [SEG_W-1:0] seg_thousands;
		logic [SEG_W-1:0] seg_hundreds;
		logic [SEG_W-1:0] seg_tens;
		logic [SEG_W-1:0] seg_ones;
	} out_item_t;

	// Seven-segment pattern without point, bit 0 is segment a.
	function automatic logic [SEG_W-1:0] seg7(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h27;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/dudc_front.sv */
module dudc_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  dudc_pkg::in_item_t in_item,
	input  logic               q_full,
	output logic               push,
	output dudc_pkg::op_t      push_op
);
	import dudc_pkg::*;

	logic keep;

	// Items that cause no output are taken and dropped here.
	always_comb begin
		keep = 1'b1;
		push_op = OP_REPORT;
		case (in_item.command)
			CMD_INC: push_op = OP_UP;
			CMD_DEC: push_op = OP_DOWN;
			CMD_RX: begin
				if (in_item.rx_byte == CHAR_U_UPPER || in_item.rx_byte == CHAR_U_LOWER) begin
					push_op = OP_UP;
				end else if (in_item.rx_byte == CHAR_D_UPPER
						|| in_item.rx_byte == CHAR_D_LOWER) begin
					push_op = OP_DOWN;
				end else begin
					keep = 1'b0;
				end
			end
			CMD_REPORT: push_op = OP_REPORT;
			default: keep = 1'b0;
		endcase
	end

	assign in_ready = !q_full;
	assign push = in_valid && in_ready && keep;

endmodule

/* hw/rtl/dudc_queue.sv */
module dudc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dudc_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output dudc_pkg::op_t head_op
);
	import dudc_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	op_t entries_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] count_q;

	assign valid = count_q != '0;
	assign full = count_q == (PW+1)'(QUEUE_DEPTH);
	assign head_op = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/dudc_back.sv */
module dudc_back #(
	parameter int NUM_DIGITS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  dudc_pkg::op_t       q_op,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output dudc_pkg::out_item_t out_item
);
	import dudc_pkg::*;

	`include "decimal_up_down_counter_report_macros.svh"

	function automatic int unsigned pow10(input int n);
		int unsigned p;
		p = 1;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	localparam int KW = $clog2(NUM_DIGITS + 2);
	localparam logic [KW-1:0] K_CR = KW'(NUM_DIGITS);
	localparam logic [KW-1:0] K_LAST = KW'(NUM_DIGITS + 1);
	// Binary value of all nines, kept to the width of the count field.
	localparam logic [COUNT_W-1:0] WRAP_DOWN = COUNT_W'(pow10(NUM_DIGITS) - 1);

	logic [NUM_DIGITS-1:0][3:0] digits_q;
	logic [NUM_DIGITS-1:0][3:0] digits_nxt;
	logic [NUM_DIGITS-1:0][3:0] sh_q;
	logic [COUNT_W-1:0] count_bin_q;
	logic [COUNT_W-1:0] count_bin_nxt;
	logic all_nines;
	logic all_zero;
	logic up_run;
	logic down_run;
	logic busy_q;
	logic [KW-1:0] k_q;
	logic load_out;
	logic out_valid_q;
	out_item_t out_q;
	out_item_t out_d;
	logic [SEG_W-1:0] seg [4];

	// Ripple the carry or borrow through the digits, ones digit first.
	always_comb begin
		digits_nxt = digits_q;
		up_run = 1'b1;
		down_run = 1'b1;
		all_nines = 1'b1;
		all_zero = 1'b1;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			all_nines = all_nines && (digits_q[i] == 4'd9);
			all_zero = all_zero && (digits_q[i] == 4'd0);
			if (q_op == OP_UP && up_run) begin
				if (digits_q[i] >= 4'd9) begin
					digits_nxt[i] = 4'd0;
				end else begin
					digits_nxt[i] = digits_q[i] + 4'd1;
					up_run = 1'b0;
				end
			end
			if (q_op == OP_DOWN && down_run) begin
				if (digits_q[i] == 4'd0) begin
					digits_nxt[i] = 4'd9;
				end else begin
					digits_nxt[i] = digits_q[i] - 4'd1;
					down_run = 1'b0;
				end
			end
		end
	end

	// A binary copy of the count avoids rebuilding it from the digits.
	always_comb begin
		case (q_op)
			OP_UP: count_bin_nxt = all_nines ? '0 : count_bin_q + 1'b1;
			OP_DOWN: count_bin_nxt = all_zero ? WRAP_DOWN : count_bin_q - 1'b1;
			default: count_bin_nxt = count_bin_q;
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_seg
			if (g < NUM_DIGITS) begin : g_have
				assign seg[g] = seg7(digits_q[g]);
			end else begin : g_blank
				assign seg[g] = '0;
			end
		end
	endgenerate

	assign load_out = busy_q && (!out_valid_q || out_ready);
	// The next item is taken up while the line feed of the current one loads.
	assign pop = q_valid && (!busy_q || (load_out && k_q == K_LAST));

	always_comb begin
		out_d.last_byte = k_q == K_LAST;
		if (k_q < K_CR) begin
			out_d.tx_byte = CHAR_ZERO + {4'b0, sh_q[NUM_DIGITS-1]};
		end else if (k_q == K_CR) begin
			out_d.tx_byte = CHAR_CR;
		end else begin
			out_d.tx_byte = CHAR_LF;
		end
		out_d.count_value = count_bin_q;
		out_d.seg_thousands = seg[3];
		out_d.seg_hundreds = seg[2];
		out_d.seg_tens = seg[1];
		out_d.seg_ones = seg[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			count_bin_q <= '0;
			busy_q <= 1'b0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				digits_q <= digits_nxt;
				count_bin_q <= count_bin_nxt;
				busy_q <= 1'b1;
				k_q <= '0;
			end else if (load_out) begin
				k_q <= k_q + 1'b1;
				if (k_q == K_LAST) begin
					busy_q <= 1'b0;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Digit shifter for the report, most significant digit at the top.
	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q <= digits_nxt;
		end else if (load_out && k_q < K_CR) begin
			for (int i = NUM_DIGITS - 1; i > 0; i--) begin
				sh_q[i] <= sh_q[i-1];
			end
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	`DUDC_ASSERT_SAME(a_pop_only_when_free, pop, !busy_q || k_q == K_LAST)
	`DUDC_ASSERT_NEXT(a_pop_starts_report, pop, busy_q && k_q == '0)
	`DUDC_ASSERT_SAME(a_last_is_lf, out_valid_q && out_q.last_byte, out_q.tx_byte == CHAR_LF)
	`DUDC_ASSERT_NEXT(a_up_wraps_to_zero, pop && q_op == OP_UP && all_nines, count_bin_q == '0)

endmodule

/* hw/rtl/decimal_up_down_counter_report.sv */
// Decimal up/down counter with serial report. Each step-up, step-down, matching received
// character or report item produces NUM_DIGITS + 2 output items (six at four digits): the
// ASCII digits most significant first, then CR, then LF flagged as last, each carrying the
// count and the segment patterns after the step. One output item leaves per cycle while a
// report runs and out_ready is high, and a queued item's first byte comes right after the
// previous line feed in the single output register. A two-entry queue between the decoder
// and the report engine lets items arrive while a report is sent; received bytes other than
// U, u, D or d are taken and produce nothing. An item reaching an idle block is queued, then
// popped into the report engine, and its first byte is then registered at the output.
module decimal_up_down_counter_report #(
	parameter int NUM_DIGITS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dudc_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output dudc_pkg::out_item_t out_item
);
	import dudc_pkg::*;

	logic push;
	op_t push_op;
	logic q_full;
	logic q_valid;
	op_t q_op;
	logic pop;

	dudc_front u_front (
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.q_full(q_full),
		.push(push),
		.push_op(push_op)
	);

	dudc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_op(push_op),
		.full(q_full),
		.pop(pop),
		.valid(q_valid),
		.head_op(q_op)
	);

	dudc_back #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_op(q_op),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

endmodule
